@@ hdl/srms_pkg.sv @@
`timescale 1ns / 1ps

package srms_pkg;

   localparam int WIN_W      = 13;
   localparam logic [WIN_W-1:0] WIN_RESET = 13'd1024;
   localparam int WIN_LIMIT  = 8191;

   localparam int OUT_W      = 16;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index taken from paddr above the byte offset
   localparam logic REG_WINDOW = 1'b0;

   typedef logic [WIN_W-1:0] window_type;
   typedef logic [OUT_W-1:0] level_type;

endpackage

@@ hdl/srms_req_if.sv @@
`timescale 1ns / 1ps

interface srms_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/srms_rsp_if.sv @@
`timescale 1ns / 1ps

interface srms_rsp_if ();
   import srms_pkg::*;

   logic      valid;
   logic      ready;
   level_type rms_level;

   modport source (output valid, output rms_level, input ready);
   modport sink   (input valid, input rms_level, output ready);
endinterface

@@ hdl/srms_ram.sv @@
`timescale 1ns / 1ps

module srms_ram #(
   parameter int WIDTH  = 31,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/srms_div.sv @@
`timescale 1ns / 1ps

module srms_div #(
   parameter int DIVIDEND_W = 43,
   parameter int DIVISOR_W  = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/srms_sqrt.sv @@
`timescale 1ns / 1ps

module srms_sqrt #(
   parameter int RAD_W  = 43,
   parameter int ROOT_W = (RAD_W + 1) / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int PAD_W = 2 * ROOT_W;
   localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] shifted;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;
   logic              fits;

   // digit-by-digit square root, one root bit a cycle
   always_comb begin
      shifted = {rem_ff[ROOT_W:0], rad_ff[PAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = shifted - trial;
      fits    = (shifted >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W - 1);
         rad_in  = PAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[PAD_W-3:0], 2'b00};
         rem_in  = fits ? diff[ROOT_W+1:0] : shifted[ROOT_W+1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hdl/sliding_window_rms.sv @@
`timescale 1ns / 1ps

// Moving-window RMS meter. Each sample item is squared; the square replaces the
// oldest one in a ring memory of MAX_WINDOW entries, a running sum is kept, and
// the result item is floor(sqrt(floor(sum / N))) with N the window_length
// register (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW). One item
// is in work at a time and goes from acceptance to result in these steps: the
// running-sum update in S_UPD and S_ADD, the first of which uses the memory read,
// the load of the bit-serial divider and its steps, a hand-over and the load of the
// bit-serial square root, its steps, a hand-over and the load of the output
// register, which waits while the previous result is not yet taken. A new item can
// be accepted no sooner than the cycle after the previous result is loaded into
// the output register. There is no clearing pass: a wrap flag marks ring entries
// not yet written since reset or the last write of window_length, and such
// entries read as zero. Writing window_length empties the window; it is to be
// written only while idle, which the block itself does not enforce.
module sliding_window_rms #(
   parameter int MAX_WINDOW  = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   srms_req_if.sink                            req_chan,
   srms_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [srms_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [srms_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [srms_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import srms_pkg::*;

   localparam int PW      = $clog2(MAX_WINDOW);
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
   localparam int SUM_W   = SQ_W + PW;
   localparam int ROOT_W  = (SUM_W + 1) / 2;
   localparam int CW      = (PW + 1 > WIN_W) ? PW + 1 : WIN_W;
   localparam int WIN_CAP = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPD,
      S_ADD,
      S_DIV,
      S_SQRT,
      S_OUT
   } state_type;

   state_type                state_ff;
   window_type               win_ff;
   logic [PW-1:0]            pos_ff;
   logic                     wrapped_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic                     div_start_ff;
   logic                     sqrt_start_ff;
   logic                     rsp_valid_ff;
   level_type                rsp_level_ff;

   logic                     cfg_write;
   logic                     accept;
   window_type               n_eff;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] sq_full;
   logic [SQ_W-1:0]          old_sq;
   logic [SQ_W-1:0]          mem_rd_data;
   logic [CW-1:0]            pos_next;
   logic                     pos_wrap;
   logic                     div_done;
   logic [SUM_W-1:0]         quotient;
   logic                     sqrt_done;
   logic [ROOT_W-1:0]        root;
   logic [ROOT_W-1:0]        root_sat;
   logic                     out_free;

   // configuration port
   assign cfg_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1] == REG_WINDOW);
   assign pready    = 1'b1;
   assign prdata    = (paddr[CSR_ADDR_W-1] == REG_WINDOW) ? CSR_DATA_W'(win_ff) : '0;

   always_comb begin
      n_eff = win_ff;
      if (win_ff == '0) begin
         n_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(WIN_CAP)) begin
         n_eff = WIN_W'(WIN_CAP);
      end
   end

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign mag     = req_chan.sample[SAMPLE_BITS-1] ? (~req_chan.sample + 1'b1)
                                                   : req_chan.sample;
   assign sq_full = mag * mag;

   assign old_sq   = wrapped_ff ? mem_rd_data : '0;
   assign pos_next = CW'(pos_ff) + 1'b1;
   assign pos_wrap = (pos_next >= CW'(n_eff));

   assign root_sat = (root > (ROOT_W'(1) << (SAMPLE_BITS - 1)))
                     ? (ROOT_W'(1) << (SAMPLE_BITS - 1)) : root;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   srms_ram #(
      .WIDTH (SQ_W),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (state_ff == S_UPD),
      .wr_addr (pos_ff),
      .wr_data (sq_ff),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (mem_rd_data)
   );

   srms_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (WIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (n_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   srms_sqrt #(
      .RAD_W  (SUM_W),
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (quotient),
      .done     (sqrt_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         win_ff        <= WIN_RESET;
         pos_ff        <= '0;
         wrapped_ff    <= 1'b0;
         sum_ff        <= '0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_write) begin
            win_ff     <= pwdata[WIN_W-1:0];
            pos_ff     <= '0;
            wrapped_ff <= 1'b0;
            sum_ff     <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               sum_ff <= sum_ff - SUM_W'(old_sq);
               if (pos_wrap) begin
                  pos_ff     <= '0;
                  wrapped_ff <= 1'b1;
               end else begin
                  pos_ff <= pos_next[PW-1:0];
               end
               state_ff <= S_ADD;
            end
            S_ADD: begin
               sum_ff       <= sum_ff + SUM_W'(sq_ff);
               div_start_ff <= 1'b1;
               state_ff     <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= OUT_W'(root_sat);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (accept) begin
         sq_ff <= sq_full[SQ_W-1:0];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.rms_level = rsp_level_ff;

endmodule
